FILE: sv/btr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_pkg
// Shared constants, register indexes and the 5x7 font for the text rasterizer.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int MAX_SCALE_DEF  = 8;
  localparam int COORD_BITS_DEF = 16;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int ADVANCE     = 6;   // pen step per glyph, in glyph pixels
  localparam int LINE_PITCH  = 8;   // pen step per newline, in glyph pixels
  localparam int FONT_GLYPHS = 96;

  localparam logic [7:0] NEWLINE     = 8'd10;
  localparam logic [7:0] FIRST_PRINT = 8'd32;
  localparam logic [7:0] LAST_PRINT  = 8'd127;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEXT_SCALE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [15:0] ORIGIN_X_RST     = 16'd0;
  localparam logic [15:0] ORIGIN_Y_RST     = 16'd0;
  localparam logic [3:0]  TEXT_SCALE_RST   = 4'd1;
  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [10:0] FRAME_HEIGHT_RST = 11'd180;

  typedef logic [4:0] glyph_row_t;

  // Glyph rows top first; bit 4 is the leftmost column. Entry 0 is the blank.
  localparam glyph_row_t FONT_ROM [FONT_GLYPHS][GLYPH_ROWS] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4, 5'd0},
    '{5'd10, 5'd10, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd10, 5'd31, 5'd10, 5'd31, 5'd10, 5'd0, 5'd0},
    '{5'd4, 5'd14, 5'd20, 5'd14, 5'd5, 5'd14, 5'd4},
    '{5'd17, 5'd18, 5'd4, 5'd8, 5'd19, 5'd0, 5'd0},
    '{5'd8, 5'd20, 5'd8, 5'd21, 5'd18, 5'd13, 5'd0},
    '{5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd2, 5'd4, 5'd4, 5'd4, 5'd4, 5'd2, 5'd0},
    '{5'd8, 5'd4, 5'd4, 5'd4, 5'd4, 5'd8, 5'd0},
    '{5'd0, 5'd10, 5'd4, 5'd31, 5'd4, 5'd10, 5'd0},
    '{5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd4, 5'd8},
    '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0},
    '{5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0, 5'd0},
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd14, 5'd0},
    '{5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd14, 5'd0},
    '{5'd14, 5'd17, 5'd2, 5'd4, 5'd8, 5'd31, 5'd0},
    '{5'd14, 5'd17, 5'd6, 5'd1, 5'd17, 5'd14, 5'd0},
    '{5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd0},
    '{5'd31, 5'd16, 5'd30, 5'd1, 5'd17, 5'd14, 5'd0},
    '{5'd6, 5'd8, 5'd30, 5'd17, 5'd17, 5'd14, 5'd0},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd0},
    '{5'd14, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14, 5'd0},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd14, 5'd0},
    '{5'd0, 5'd4, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
    '{5'd0, 5'd4, 5'd0, 5'd0, 5'd4, 5'd8, 5'd0},
    '{5'd2, 5'd4, 5'd8, 5'd4, 5'd2, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0},
    '{5'd8, 5'd4, 5'd2, 5'd4, 5'd8, 5'd0, 5'd0},
    '{5'd14, 5'd17, 5'd2, 5'd4, 5'd0, 5'd4, 5'd0},
    '{5'd14, 5'd17, 5'd21, 5'd23, 5'd16, 5'd14, 5'd0},
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd0},
    '{5'd30, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30, 5'd0},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd17, 5'd14, 5'd0},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30, 5'd0},
    '{5'd31, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31, 5'd0},
    '{5'd31, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16, 5'd0},
    '{5'd14, 5'd17, 5'd16, 5'd19, 5'd17, 5'd15, 5'd0},
    '{5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17, 5'd0},
    '{5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14, 5'd0},
    '{5'd1, 5'd1, 5'd1, 5'd1, 5'd17, 5'd14, 5'd0},
    '{5'd17, 5'd18, 5'd28, 5'd18, 5'd17, 5'd17, 5'd0},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31, 5'd0},
    '{5'd17, 5'd27, 5'd21, 5'd17, 5'd17, 5'd17, 5'd0},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd0},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14, 5'd0},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd0},
    '{5'd14, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13, 5'd0},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd18, 5'd17, 5'd0},
    '{5'd14, 5'd17, 5'd14, 5'd1, 5'd17, 5'd14, 5'd0},
    '{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14, 5'd0},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4, 5'd0},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd10, 5'd0},
    '{5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd17, 5'd0},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd0},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31, 5'd0},
    '{5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14, 5'd0},
    '{5'd16, 5'd8, 5'd4, 5'd2, 5'd1, 5'd0, 5'd0},
    '{5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14, 5'd0},
    '{5'd4, 5'd10, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31, 5'd0},
    '{5'd8, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd14, 5'd1, 5'd15, 5'd17, 5'd15, 5'd0},
    '{5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd30, 5'd0},
    '{5'd0, 5'd14, 5'd16, 5'd16, 5'd16, 5'd14, 5'd0},
    '{5'd1, 5'd1, 5'd15, 5'd17, 5'd17, 5'd15, 5'd0},
    '{5'd0, 5'd14, 5'd17, 5'd31, 5'd16, 5'd14, 5'd0},
    '{5'd6, 5'd8, 5'd28, 5'd8, 5'd8, 5'd8, 5'd0},
    '{5'd0, 5'd15, 5'd17, 5'd15, 5'd1, 5'd14, 5'd0},
    '{5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd0},
    '{5'd4, 5'd0, 5'd12, 5'd4, 5'd4, 5'd14, 5'd0},
    '{5'd2, 5'd0, 5'd2, 5'd2, 5'd18, 5'd12, 5'd0},
    '{5'd16, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd0},
    '{5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14, 5'd0},
    '{5'd0, 5'd26, 5'd21, 5'd21, 5'd21, 5'd21, 5'd0},
    '{5'd0, 5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd0},
    '{5'd0, 5'd14, 5'd17, 5'd17, 5'd17, 5'd14, 5'd0},
    '{5'd0, 5'd30, 5'd17, 5'd30, 5'd16, 5'd16, 5'd0},
    '{5'd0, 5'd15, 5'd17, 5'd15, 5'd1, 5'd1, 5'd0},
    '{5'd0, 5'd22, 5'd24, 5'd16, 5'd16, 5'd16, 5'd0},
    '{5'd0, 5'd15, 5'd16, 5'd14, 5'd1, 5'd30, 5'd0},
    '{5'd8, 5'd28, 5'd8, 5'd8, 5'd8, 5'd6, 5'd0},
    '{5'd0, 5'd17, 5'd17, 5'd17, 5'd17, 5'd15, 5'd0},
    '{5'd0, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4, 5'd0},
    '{5'd0, 5'd17, 5'd17, 5'd21, 5'd21, 5'd10, 5'd0},
    '{5'd0, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd0},
    '{5'd0, 5'd17, 5'd17, 5'd15, 5'd1, 5'd14, 5'd0},
    '{5'd0, 5'd31, 5'd2, 5'd4, 5'd8, 5'd31, 5'd0},
    '{5'd6, 5'd8, 5'd8, 5'd16, 5'd8, 5'd8, 5'd6},
    '{5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd12, 5'd2, 5'd2, 5'd1, 5'd2, 5'd2, 5'd12},
    '{5'd0, 5'd8, 5'd21, 5'd2, 5'd0, 5'd0, 5'd0},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31}
  };

endpackage

FILE: sv/bitmap_text_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer
// 5x7 character generator: one character code in, scaled pixel-row masks out.
// ----------------------------------------------------------------------------
// Usage: each character other than a newline (blank glyphs included) produces
// 7*scale row transfers, one per cycle while out_ready allows; a newline is
// taken and produces nothing.
// The row sequencer steps one mask row per cycle into the output register,
// holding while the output is stalled; the next character is taken in the
// cycle that the last row of the current one leaves the sequencer, so
// characters stream with no gap. Register writes must only be issued while
// no character is in flight; writes to indexes 0 to 4 reload the pen from
// the origin.
module bitmap_text_rasterizer #(
  parameter int MAX_SCALE  = btr_pkg::MAX_SCALE_DEF,
  parameter int COORD_BITS = btr_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [btr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [btr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // characters
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         char_code,
  // row results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 row_x,
  output logic signed [15:0]                 row_y,
  output logic [btr_pkg::GLYPH_COLS*MAX_SCALE-1:0] pixel_mask,
  output logic                               last_row
);

  localparam int MW  = btr_pkg::GLYPH_COLS * MAX_SCALE;
  localparam int SCW = $clog2(MAX_SCALE + 1);
  localparam int SIW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int XW  = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
  localparam int YW  = ((COORD_BITS + 1) > 12) ? (COORD_BITS + 1) : 12;

  // configuration registers
  logic [15:0] origin_x, origin_y;
  logic [3:0]  text_scale;
  logic [10:0] frame_width, frame_height;
  logic [15:0] origin_x_next, origin_y_next;
  logic        cfg_hit;

  // pen
  logic signed [COORD_BITS-1:0] pen_x, pen_y;

  // row sequencer
  logic                         busy;
  logic [6:0]                   glyph_idx;
  logic [2:0]                   row_idx;
  logic [SCW-1:0]               sub_idx;
  logic signed [COORD_BITS-1:0] work_x;
  logic signed [YW-1:0]         cur_y;
  logic [MW-1:0]                col_mask;

  logic [SCW-1:0] sc_eff;
  logic [SIW-1:0] sc_sel;
  logic           in_fire, is_newline, step_fire, last_step;
  logic [6:0]     glyph_idx_next;
  logic [MW-1:0]  col_mask_next;
  logic [MW-1:0]  row_mask;
  logic           y_inside;
  btr_pkg::glyph_row_t glyph_bits;
  logic [MW-1:0]  exp_mask [MAX_SCALE];

  // scale zero acts as one, large values saturate
  always_comb begin
    if (text_scale == 4'd0) begin
      sc_eff = SCW'(1);
    end else if (text_scale > 4'(MAX_SCALE)) begin
      sc_eff = SCW'(MAX_SCALE);
    end else begin
      sc_eff = SCW'(text_scale);
    end
  end
  assign sc_sel = SIW'(sc_eff - SCW'(1));

  // ---- configuration ----
  always_comb begin
    origin_x_next = origin_x;
    origin_y_next = origin_y;
    cfg_hit       = 1'b0;
    case (cfg_index)
      btr_pkg::REG_ORIGIN_X: begin
        origin_x_next = cfg_data;
        cfg_hit       = 1'b1;
      end
      btr_pkg::REG_ORIGIN_Y: begin
        origin_y_next = cfg_data;
        cfg_hit       = 1'b1;
      end
      btr_pkg::REG_TEXT_SCALE,
      btr_pkg::REG_FRAME_WIDTH,
      btr_pkg::REG_FRAME_HEIGHT: begin
        cfg_hit = 1'b1;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= btr_pkg::ORIGIN_X_RST;
      origin_y     <= btr_pkg::ORIGIN_Y_RST;
      text_scale   <= btr_pkg::TEXT_SCALE_RST;
      frame_width  <= btr_pkg::FRAME_WIDTH_RST;
      frame_height <= btr_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      origin_x <= origin_x_next;
      origin_y <= origin_y_next;
      if (cfg_index == btr_pkg::REG_TEXT_SCALE) begin
        text_scale <= cfg_data[3:0];
      end
      if (cfg_index == btr_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[10:0];
      end
      if (cfg_index == btr_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[10:0];
      end
    end
  end

  // ---- handshake ----
  assign last_step  = (row_idx == 3'(btr_pkg::GLYPH_ROWS - 1)) &&
                      (sub_idx == sc_eff - SCW'(1));
  assign step_fire  = busy && (!out_valid || out_ready);
  assign in_ready   = !busy || (step_fire && last_step);
  assign in_fire    = in_valid && in_ready;
  assign is_newline = (char_code == btr_pkg::NEWLINE);

  // ---- pen ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= COORD_BITS'($signed(btr_pkg::ORIGIN_X_RST));
      pen_y <= COORD_BITS'($signed(btr_pkg::ORIGIN_Y_RST));
    end else if (cfg_write) begin
      if (cfg_hit) begin
        pen_x <= COORD_BITS'($signed(origin_x_next));
        pen_y <= COORD_BITS'($signed(origin_y_next));
      end
    end else if (in_fire) begin
      if (is_newline) begin
        pen_x <= COORD_BITS'($signed(origin_x));
        pen_y <= pen_y + COORD_BITS'(btr_pkg::LINE_PITCH * sc_eff);
      end else begin
        pen_x <= pen_x + COORD_BITS'(btr_pkg::ADVANCE * sc_eff);
      end
    end
  end

  // ---- per-character setup ----
  assign glyph_idx_next = (char_code < btr_pkg::FIRST_PRINT || char_code > btr_pkg::LAST_PRINT)
                        ? 7'd0 : 7'(char_code - btr_pkg::FIRST_PRINT);

  // column clip: keep bit i when 0 <= pen_x + i < frame_width
  logic signed [XW-1:0] px_ext, x_lo, x_hi;
  assign px_ext = XW'(pen_x);
  assign x_lo   = -px_ext;
  assign x_hi   = $signed(XW'(frame_width)) - px_ext;

  for (genvar i = 0; i < MW; i++) begin : g_col
    localparam logic signed [XW-1:0] IV = XW'(i);
    assign col_mask_next[i] = (IV >= x_lo) && (IV < x_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_fire) begin
      busy <= !is_newline;
    end else if (step_fire && last_step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !is_newline) begin
      glyph_idx <= glyph_idx_next;
      row_idx   <= 3'd0;
      sub_idx   <= '0;
      work_x    <= pen_x;
      cur_y     <= YW'(pen_y);
      col_mask  <= col_mask_next;
    end else if (step_fire) begin
      cur_y <= cur_y + YW'(1);
      if (sub_idx == sc_eff - SCW'(1)) begin
        sub_idx <= '0;
        row_idx <= row_idx + 3'd1;
      end else begin
        sub_idx <= sub_idx + SCW'(1);
      end
    end
  end

  // ---- row mask ----
  assign glyph_bits = btr_pkg::FONT_ROM[glyph_idx][row_idx];

  // one fixed wiring per scale: mask bit i takes glyph column i/scale
  for (genvar g = 1; g <= MAX_SCALE; g++) begin : g_scale
    for (genvar i = 0; i < MW; i++) begin : g_bit
      if (i < btr_pkg::GLYPH_COLS * g) begin : g_on
        localparam int SRC_BIT = btr_pkg::GLYPH_COLS - 1 - i / g;
        assign exp_mask[g-1][i] = glyph_bits[SRC_BIT];
      end else begin : g_off
        assign exp_mask[g-1][i] = 1'b0;
      end
    end
  end

  assign y_inside = !cur_y[YW-1] && (cur_y < $signed(YW'(frame_height)));
  assign row_mask = y_inside ? (exp_mask[sc_sel] & col_mask) : '0;

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      row_x      <= 16'(work_x);
      row_y      <= 16'(cur_y);
      pixel_mask <= row_mask;
      last_row   <= last_step;
    end
  end

`ifndef SYNTHESIS
  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (sub_idx < sc_eff))
    else $error("sub-row counter beyond scale");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (row_idx < 3'(btr_pkg::GLYPH_ROWS)))
    else $error("glyph row counter beyond last row");

  a_newline_no_rows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_newline) |=> !busy)
    else $error("newline started a glyph");

  a_mask_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pixel_mask >> (btr_pkg::GLYPH_COLS * sc_eff)) == '0))
    else $error("mask bits set beyond 5*scale");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (step_fire && last_step && !in_fire) |=> !busy)
    else $error("sequencer busy after last row");
`endif

endmodule
